[sv/thc_pkg.sv]
package thc_pkg;

  // Defaults for the top-level parameters
  localparam int PatternLenDef = 10;
  localparam int TimeBitsDef   = 16;

  // Level range of the voltage control field
  localparam logic [4:0] LevelMin  = 5'd12;
  localparam logic [4:0] LevelMax  = 5'd31;
  localparam logic [4:0] LevelMask = 5'h1F;

  // Bits of the enable control byte
  localparam int EnBit         = 7;
  localparam int PolarityShift = 4;

  // Register reset values
  localparam logic [15:0] TimeoutRst   = 16'd15000;
  localparam logic [15:0] BoostMinRst  = 16'd100;
  localparam logic [15:0] BoostMaxRst  = 16'd500;
  localparam logic [4:0]  BoostLvlRst  = 5'd28;
  localparam logic [15:0] TriggerRst   = 16'd150;
  localparam logic [1:0]  DriveModeRst = 2'd0;
  localparam logic        ActLowRst    = 1'b0;
  localparam logic [4:0]  InitLevelRst = 5'd31;

  typedef enum logic [2:0] {
    CMD_ENABLE  = 3'd0,
    CMD_TICK    = 3'd1,
    CMD_SET_LVL = 3'd2,
    CMD_WR_PAT  = 3'd3,
    CMD_SUSPEND = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    REG_TIMEOUT   = 3'd0,
    REG_BOOST_MIN = 3'd1,
    REG_BOOST_MAX = 3'd2,
    REG_BOOST_LVL = 3'd3,
    REG_TRIGGER   = 3'd4,
    REG_MODE      = 3'd5,
    REG_ACT_LOW   = 3'd6,
    REG_INIT_LVL  = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [15:0] timeout;
    logic [15:0] boost_lo;
    logic [15:0] boost_hi;
    logic [4:0]  boost_lvl;
    logic [15:0] trigger;
  } thc_cfg_t;

  typedef struct packed {
    logic        drive_state;
    logic        hw_on;
    logic        timer_armed;
    logic        pat_running;
    logic [4:0]  applied_lvl;
    logic [4:0]  wanted_lvl;
    logic [4:0]  saved_lvl;
    logic [15:0] on_time;
    logic [15:0] countdown;
  } thc_state_t;

  function automatic logic [4:0] clamp_lvl5(logic [4:0] v);
    return (v < LevelMin) ? LevelMin : v;
  endfunction

  function automatic logic [4:0] clamp_lvl8(logic [7:0] v);
    logic [4:0] r;
    if (v < 8'(LevelMin)) r = LevelMin;
    else if (v > 8'(LevelMax)) r = LevelMax;
    else r = v[4:0];
    return r;
  endfunction

  function automatic logic [15:0] pattern_init(int i);
    logic [15:0] r;
    case (i)
      0: r = 16'd150;
      1: r = 16'd50;
      2: r = 16'd350;
      3: r = 16'd50;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] time_mask(int bits);
    return (bits >= 16) ? 16'hFFFF : 16'((32'd1 << bits) - 32'd1);
  endfunction

endpackage

[sv/timed_haptic_controller.sv]
// Timed vibrator drive controller.
// Input channel (in_valid_i / in_stall_o) carries one command per transaction:
// enable for a duration, 1 ms tick, set level, write pattern entry, suspend.
// Every accepted command yields exactly one status transaction on the output
// channel (out_valid_o / out_stall_i): drive state, applied level, enable
// control byte, on-time and pattern busy, all taken after the command.
// Status is registered at the edge that accepts its command. Throughput is
// one command per cycle while in_stall_o is low; the command is decoded and
// the state updated by a single level of logic between the state registers
// and the status register, with the pattern table read at one address.
// While the status register holds a transaction and out_stall_i is high,
// in_stall_o is raised and the status holds; when it drains, a new command is
// taken in the same cycle.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at once;
// the user is to make them only while no status is outstanding; the block
// does not enforce this. An initial-level write also reloads the applied, wanted and saved levels.
// Reset (rst_ni low) restores register defaults, turns the drive off, stops
// any pattern, reloads the default pattern and empties the status register.
module timed_haptic_controller import thc_pkg::*; #(
  parameter int PATTERN_LEN = PatternLenDef,
  parameter int TIME_BITS   = TimeBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  command_i,
  input  logic [15:0] duration_ms_i,
  input  logic [7:0]  level_value_i,
  input  logic [3:0]  pattern_slot_i,
  input  logic [15:0] pattern_time_ms_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        drive_on_o,
  output logic [4:0]  voltage_level_o,
  output logic [7:0]  enable_ctl_byte_o,
  output logic [15:0] active_time_ms_o,
  output logic        pattern_busy_o
);

  localparam int SegW  = $clog2(PATTERN_LEN + 1);
  localparam int IdxW  = $clog2(PATTERN_LEN);
  localparam int SlotW = (SegW > 4) ? SegW : 4;
  localparam logic [15:0] TimeMask = time_mask(TIME_BITS);

  thc_cfg_t        cfg_q;
  logic [1:0]      mode_q;
  logic            act_low_q;
  thc_state_t      st_q, st_d;
  logic [SegW-1:0] seg_q, seg_d;
  logic [15:0]     store_q [PATTERN_LEN];
  logic [IdxW-1:0] rd_idx;
  logic            accept;
  logic [SlotW-1:0] slot_ext;
  logic            slot_ok;
  logic [4:0]      init_lvl;
  logic [7:0]      ctl_d;
  logic            out_valid_q;

  assign accept   = in_valid_i && !in_stall_o;
  assign slot_ext = SlotW'(pattern_slot_i);
  assign slot_ok  = slot_ext < SlotW'(PATTERN_LEN);
  assign init_lvl = clamp_lvl5(cfg_data_i[4:0] & LevelMask);

  thc_step #(
    .PATTERN_LEN(PATTERN_LEN),
    .TIME_BITS  (TIME_BITS)
  ) u_step (
    .cfg_i        (cfg_q),
    .st_i         (st_q),
    .seg_i        (seg_q),
    .command_i    (command_i),
    .duration_ms_i(duration_ms_i),
    .level_value_i(level_value_i),
    .rd_idx_o     (rd_idx),
    .rd_data_i    (store_q[rd_idx]),
    .st_o         (st_d),
    .seg_o        (seg_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout   <= TimeoutRst;
      cfg_q.boost_lo  <= BoostMinRst;
      cfg_q.boost_hi  <= BoostMaxRst;
      cfg_q.boost_lvl <= BoostLvlRst;
      cfg_q.trigger   <= TriggerRst;
      mode_q          <= DriveModeRst;
      act_low_q       <= ActLowRst;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_TIMEOUT:   cfg_q.timeout   <= cfg_data_i & TimeMask;
        REG_BOOST_MIN: cfg_q.boost_lo  <= cfg_data_i & TimeMask;
        REG_BOOST_MAX: cfg_q.boost_hi  <= cfg_data_i & TimeMask;
        REG_BOOST_LVL: cfg_q.boost_lvl <= cfg_data_i[4:0];
        REG_TRIGGER:   cfg_q.trigger   <= cfg_data_i & TimeMask;
        REG_MODE:      mode_q          <= cfg_data_i[1:0];
        REG_ACT_LOW:   act_low_q       <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.drive_state <= 1'b0;
      st_q.hw_on       <= 1'b0;
      st_q.timer_armed <= 1'b0;
      st_q.pat_running <= 1'b0;
      st_q.applied_lvl <= InitLevelRst;
      st_q.wanted_lvl  <= InitLevelRst;
      st_q.saved_lvl   <= InitLevelRst;
      st_q.on_time     <= '0;
      st_q.countdown   <= '0;
      seg_q            <= '0;
    end else if (cfg_we_i && cfg_reg_e'(cfg_idx_i) == REG_INIT_LVL) begin
      st_q.applied_lvl <= init_lvl;
      st_q.wanted_lvl  <= init_lvl;
      st_q.saved_lvl   <= init_lvl;
    end else if (accept) begin
      st_q  <= st_d;
      seg_q <= seg_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PATTERN_LEN; i++) begin
        store_q[i] <= pattern_init(i);
      end
    end else if (accept && cmd_e'(command_i) == CMD_WR_PAT && slot_ok) begin
      store_q[slot_ext[IdxW-1:0]] <= pattern_time_ms_i & TimeMask;
    end
  end

  always_comb begin
    ctl_d = '0;
    ctl_d[PolarityShift] = act_low_q;
    if (mode_q != 2'd0) ctl_d[mode_q - 2'd1] = 1'b1;
    else ctl_d[EnBit] = st_d.hw_on;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      drive_on_o        <= st_d.hw_on;
      voltage_level_o   <= st_d.applied_lvl;
      enable_ctl_byte_o <= ctl_d;
      active_time_ms_o  <= st_d.on_time;
      pattern_busy_o    <= st_d.pat_running;
    end
  end

  assign out_valid_o = out_valid_q;
  assign in_stall_o  = out_valid_q && out_stall_i;

`ifndef SYNTHESIS
  a_valid_from_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("status appeared without an accepted command");

  a_timer_xor_pattern: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(st_q.timer_armed && st_q.pat_running))
    else $error("timer armed while a pattern runs");

  a_level_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (voltage_level_o >= LevelMin))
    else $error("applied level below range");

  a_on_time_needs_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && active_time_ms_o != '0) |-> drive_on_o)
    else $error("on-time reported with drive off");
`endif

endmodule

[sv/thc_step.sv]
module thc_step import thc_pkg::*; #(
  parameter int PATTERN_LEN = PatternLenDef,
  parameter int TIME_BITS   = TimeBitsDef,
  localparam int SegW = $clog2(PATTERN_LEN + 1),
  localparam int IdxW = $clog2(PATTERN_LEN)
) (
  input  thc_cfg_t         cfg_i,
  input  thc_state_t       st_i,
  input  logic [SegW-1:0]  seg_i,
  input  logic [2:0]       command_i,
  input  logic [15:0]      duration_ms_i,
  input  logic [7:0]       level_value_i,
  output logic [IdxW-1:0]  rd_idx_o,
  input  logic [15:0]      rd_data_i,
  output thc_state_t       st_o,
  output logic [SegW-1:0]  seg_o
);

  localparam logic [15:0] TimeMask = time_mask(TIME_BITS);

  logic [15:0]     dur_m, dur_c;
  logic [SegW-1:0] rd_next, rd_sel;
  logic            rd_ok;
  logic            seg_start;
  thc_state_t      st;
  logic [SegW-1:0] seg;
  logic [4:0]      lvl;

  assign dur_m   = duration_ms_i & TimeMask;
  assign dur_c   = (dur_m > cfg_i.timeout) ? cfg_i.timeout : dur_m;
  assign rd_next = seg_i + SegW'(1);
  // enable starts at the first entry, a tick advances to the next one
  assign rd_sel   = (cmd_e'(command_i) == CMD_ENABLE) ? '0 : rd_next;
  assign rd_ok    = rd_sel < SegW'(PATTERN_LEN);
  assign rd_idx_o = rd_sel[IdxW-1:0];
  assign lvl      = clamp_lvl8(level_value_i);

  always_comb begin
    st = st_i;
    seg = seg_i;
    seg_start = 1'b0;
    case (cmd_e'(command_i))
      CMD_ENABLE: begin
        st.pat_running = 1'b0;
        st.timer_armed = 1'b0;
        if (dur_m == '0) begin
          st.drive_state = 1'b0;
          st.hw_on       = 1'b0;
          st.on_time     = '0;
          st.wanted_lvl  = st.saved_lvl;
        end else if (dur_c != '0 && dur_c == cfg_i.trigger) begin
          st.pat_running = 1'b1;
          seg = '0;
          seg_start = 1'b1;
        end else begin
          if (dur_c >= cfg_i.boost_lo && dur_c <= cfg_i.boost_hi &&
              st.wanted_lvl != cfg_i.boost_lvl) begin
            st.saved_lvl  = st.wanted_lvl;
            st.wanted_lvl = cfg_i.boost_lvl;
          end
          st.drive_state = 1'b1;
          st.hw_on       = 1'b1;
          st.applied_lvl = clamp_lvl5(st.wanted_lvl);
          st.on_time     = dur_c;
          st.countdown   = dur_c;
          st.timer_armed = 1'b1;
        end
      end
      CMD_TICK: begin
        if (st.timer_armed) begin
          if (st.countdown <= 16'd1) begin
            st.countdown   = '0;
            st.timer_armed = 1'b0;
            st.drive_state = 1'b0;
            st.hw_on       = 1'b0;
            st.on_time     = '0;
            st.wanted_lvl  = st.saved_lvl;
          end else begin
            st.countdown = st.countdown - 16'd1;
          end
        end else if (st.pat_running) begin
          if (st.countdown <= 16'd1) begin
            st.countdown = '0;
            seg = rd_next;
            seg_start = 1'b1;
          end else begin
            st.countdown = st.countdown - 16'd1;
          end
        end
      end
      CMD_SET_LVL: begin
        st.applied_lvl = lvl;
        st.wanted_lvl  = lvl;
        st.saved_lvl   = lvl;
      end
      CMD_SUSPEND: begin
        st.timer_armed = 1'b0;
        st.hw_on       = 1'b0;
        st.on_time     = '0;
      end
      default: begin
      end
    endcase

    if (seg_start) begin
      if (!rd_ok || rd_data_i == '0) begin
        // end of pattern
        st.pat_running = 1'b0;
        if (st.drive_state) begin
          st.drive_state = 1'b0;
          st.hw_on       = 1'b0;
          st.on_time     = '0;
        end
        st.wanted_lvl = st.saved_lvl;
      end else if (!rd_sel[0]) begin
        // even entries are on segments
        if (rd_data_i >= cfg_i.boost_lo && rd_data_i <= cfg_i.boost_hi) begin
          if (st.wanted_lvl != cfg_i.boost_lvl) begin
            st.saved_lvl  = st.wanted_lvl;
            st.wanted_lvl = cfg_i.boost_lvl;
          end
        end else begin
          st.wanted_lvl = st.saved_lvl;
        end
        st.drive_state = 1'b1;
        st.hw_on       = 1'b1;
        st.applied_lvl = clamp_lvl5(st.wanted_lvl);
        st.on_time     = rd_data_i;
        st.countdown   = rd_data_i;
      end else begin
        st.drive_state = 1'b0;
        st.hw_on       = 1'b0;
        st.on_time     = '0;
        st.countdown   = rd_data_i;
      end
    end
  end

  assign st_o  = st;
  assign seg_o = seg;

endmodule
